// ===== rtl/core/sas_pkg.sv =====
// Shared types and constants for the sprite animation sequencer.
// No dependencies; every other file of the block imports this package.
package sas_pkg;

   localparam int unsigned DURATION_W = 16;
   localparam int unsigned SLOT_W     = 4;
   localparam int unsigned FRAME_W    = 4;
   localparam int unsigned COUNT_W    = 5;
   localparam int unsigned CSR_DATA_W = 5;
   localparam int unsigned CSR_IDX_W  = 2;

   typedef logic [DURATION_W-1:0] duration_type;
   typedef logic [SLOT_W-1:0]     slot_type;
   typedef logic [FRAME_W-1:0]    frame_type;
   typedef logic [COUNT_W-1:0]    count_type;

   typedef enum logic {
      CMD_TICK  = 1'b0,
      CMD_WRITE = 1'b1
   } command_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_COUNT = 2'd0,
      CSR_LOOP_EN     = 2'd1,
      CSR_PINGPONG_EN = 2'd2,
      CSR_ANIM_EN     = 2'd3
   } csr_index_type;

   localparam duration_type DURATION_MAX = '1;

endpackage

// ===== rtl/core/sas_channels.sv =====
// Valid/ready channel interfaces for the sequencer's command and result streams.
// Depends on sas_pkg for the payload types.
interface sas_req_if;
   import sas_pkg::*;

   logic         valid;
   logic         ready;
   command_type  command;
   slot_type     slot;
   duration_type duration_ms;

   modport source (output valid, output command, output slot, output duration_ms,
                   input ready);
   modport sink   (input valid, input command, input slot, input duration_ms,
                   output ready);
endinterface

interface sas_rsp_if;
   import sas_pkg::*;

   logic      valid;
   logic      ready;
   frame_type frame_index;
   logic      advanced;
   logic      stopped;

   modport source (output valid, output frame_index, output advanced, output stopped,
                   input ready);
   modport sink   (input valid, input frame_index, input advanced, input stopped,
                   output ready);
endinterface

// ===== rtl/core/sprite_animation_sequencer_top.sv =====
// Sprite animation sequencer: frame timing, direction and pause control.
// Depends on sas_pkg and the channel interfaces in sas_channels.sv.
//
//   Channel   Direction  Role
//   req_chan  in         tick or duration write, valid/ready
//   rsp_chan  out        frame index, advanced and stopped flags, valid/ready
//   csr_*     in         write-only register port, no handshake
//
// Each item's state update and result are computed in the cycle of the
// transfer, and the result is captured in the result register.
// A new item is accepted every cycle while the result register is empty or
// being drained; a stall on the result side stalls the command side.
// Synchronous reset clears state; durations are undefined until written.
module sprite_animation_sequencer_top #(
   parameter int unsigned MAX_FRAMES = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   sas_req_if.sink                     req_chan,
   sas_rsp_if.source                   rsp_chan,
   input  logic                        csr_we,
   input  logic [sas_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sas_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sas_pkg::*;

   localparam int unsigned N_MAX       = (MAX_FRAMES < 31) ? MAX_FRAMES : 31;
   localparam int unsigned CUR_W       = (N_MAX > 1) ? $clog2(N_MAX) : 1;
   localparam int unsigned STORE_DEPTH = (MAX_FRAMES < 16) ? MAX_FRAMES : 16;
   localparam int unsigned IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam count_type   N_MAX_C     = COUNT_W'(N_MAX);
   localparam count_type   STORE_C     = COUNT_W'(STORE_DEPTH);

   count_type          frame_count_ff;
   logic               loop_en_ff;
   logic               pingpong_en_ff;
   logic               anim_en_ff;

   logic [CUR_W-1:0]   cur_ff;
   logic [CUR_W-1:0]   cur_in;
   logic               back_ff;
   logic               back_in;
   logic               halted_ff;
   logic               halted_in;
   duration_type       elapsed_ff;
   duration_type       elapsed_in;
   duration_type       dur_mem_ff [STORE_DEPTH];

   logic               rsp_valid_ff;
   frame_type          rsp_frame_ff;
   logic               rsp_adv_ff;
   logic               rsp_stop_ff;

   logic               req_fire;
   logic               tick_active;
   logic               hit;
   count_type          n_use;
   count_type          last;
   count_type          cur_ext;
   count_type          cl;
   count_type          next_frame;
   logic               next_back;
   logic               next_halt;
   duration_type       elapsed_inc;
   duration_type       dur_rd;
   count_type          cur_out;

   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign tick_active    = req_fire && (req_chan.command == CMD_TICK) &&
                           anim_en_ff && !halted_ff;

   always_comb begin
      if (frame_count_ff == '0) begin
         n_use = COUNT_W'(1);
      end else if (frame_count_ff > N_MAX_C) begin
         n_use = N_MAX_C;
      end else begin
         n_use = frame_count_ff;
      end
      last    = n_use - COUNT_W'(1);
      cur_ext = COUNT_W'(cur_ff);
      cl      = (cur_ext >= n_use) ? last : cur_ext;

      if (cl < STORE_C) begin
         dur_rd = dur_mem_ff[cl[IDX_W-1:0]];
      end else begin
         dur_rd = '0;
      end

      elapsed_inc = (elapsed_ff == DURATION_MAX) ? elapsed_ff
                                                 : elapsed_ff + DURATION_W'(1);
      hit = elapsed_inc >= dur_rd;

      next_frame = cl + COUNT_W'(1);
      next_back  = back_ff;
      next_halt  = halted_ff;
      if (pingpong_en_ff) begin
         if (!back_ff) begin
            if (cl >= last) begin
               next_frame = (n_use >= COUNT_W'(2)) ? n_use - COUNT_W'(2) : '0;
               next_back  = 1'b1;
               next_halt  = halted_ff || !loop_en_ff;
            end
         end else begin
            if (cl != '0) begin
               next_frame = cl - COUNT_W'(1);
            end else begin
               next_frame = (n_use >= COUNT_W'(2)) ? COUNT_W'(1) : '0;
               next_back  = 1'b0;
               next_halt  = halted_ff || !loop_en_ff;
            end
         end
      end else if (cl >= last) begin
         next_frame = loop_en_ff ? '0 : last;
         next_halt  = halted_ff || !loop_en_ff;
      end

      cur_in     = cur_ff;
      back_in    = back_ff;
      halted_in  = halted_ff;
      elapsed_in = elapsed_ff;
      if (tick_active) begin
         if (hit) begin
            cur_in     = next_frame[CUR_W-1:0];
            back_in    = next_back;
            halted_in  = next_halt;
            elapsed_in = '0;
         end else begin
            cur_in     = cl[CUR_W-1:0];
            elapsed_in = elapsed_inc;
         end
      end
      cur_out = COUNT_W'(cur_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= COUNT_W'(1);
         loop_en_ff     <= 1'b1;
         pingpong_en_ff <= 1'b0;
         anim_en_ff     <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_COUNT: frame_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_LOOP_EN:     loop_en_ff     <= csr_wdata[0];
            CSR_PINGPONG_EN: pingpong_en_ff <= csr_wdata[0];
            CSR_ANIM_EN:     anim_en_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && (req_chan.command == CMD_WRITE) &&
          (COUNT_W'(req_chan.slot) < STORE_C)) begin
         dur_mem_ff[req_chan.slot[IDX_W-1:0]] <= req_chan.duration_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         back_ff      <= 1'b0;
         halted_ff    <= 1'b0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_ff     <= cur_in;
         back_ff    <= back_in;
         halted_ff  <= halted_in;
         elapsed_ff <= elapsed_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_frame_ff <= cur_out[FRAME_W-1:0];
         rsp_adv_ff   <= tick_active && hit;
         rsp_stop_ff  <= halted_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.frame_index = rsp_frame_ff;
   assign rsp_chan.advanced    = rsp_adv_ff;
   assign rsp_chan.stopped     = rsp_stop_ff;

   // Once paused at an end, the sequencer stays paused until reset.
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(halted_ff))
      else $error("pause state cleared without reset");

   a_write_no_adv: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_chan.command == CMD_WRITE) |=> rsp_valid_ff && !rsp_adv_ff)
      else $error("duration write reported a frame change");

   a_adv_clears: assert property (@(posedge clock) disable iff (reset)
      tick_active && hit |=> (elapsed_ff == '0) && rsp_adv_ff)
      else $error("frame change did not clear the elapsed time");

   a_frozen_hold: assert property (@(posedge clock) disable iff (reset)
      req_fire && !tick_active |=> $stable(cur_ff) && $stable(elapsed_ff))
      else $error("position moved on a frozen, paused or write transfer");

endmodule

// ===== tb/sv/sprite_animation_sequencer_top_tb.sv =====
// Self-checking testbench for the sprite animation sequencer top level.
// Depends on sas_pkg, the channel interfaces and sprite_animation_sequencer_top.
// Directed and random ticks and duration writes are checked against a built-in predictor.
module sprite_animation_sequencer_top_tb;
   import sas_pkg::*;

   localparam int unsigned SEQ_FRAMES  = 16;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned LONG_HOLD   = 150;
   localparam int unsigned PHASE_ITEMS = 55;
   localparam int unsigned PHASES      = 20;

   typedef struct packed {
      command_type  command;
      slot_type     slot;
      duration_type duration_ms;
   } sequencer_cmd_type;

   typedef struct packed {
      frame_type frame_index;
      logic      advanced;
      logic      stopped;
   } frame_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   sas_req_if req_chan();
   sas_rsp_if rsp_chan();

   sprite_animation_sequencer_top #(.MAX_FRAMES(SEQ_FRAMES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   count_type     cfg_frame_count = 5'd1;
   logic          cfg_loop = 1'b1;
   logic          cfg_pingpong = 1'b0;
   logic          cfg_anim = 1'b1;
   frame_type     seq_frame = '0;
   logic          seq_backward = 1'b0;
   logic          seq_halted = 1'b0;
   duration_type  seq_elapsed = '0;
   duration_type  seq_durations [SEQ_FRAMES];

   sequencer_cmd_type pending_cmds[$];
   frame_report_type  expected_reports[$];
   int unsigned    cmds_in_flight = 0;
   int unsigned    mismatches = 0;
   int unsigned    cycle_count = 0;
   int unsigned    send_gap = 0;
   int unsigned    recv_stall = 0;
   int unsigned    hold_requests = 0;
   int unsigned    holds_done = 0;
   bit             send_idling = 1'b1;
   bit             recv_idling = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic frame_report_type step_sequencer(input command_type cmd,
                                                       input slot_type slot,
                                                       input duration_type dur);
      frame_report_type res;
      int unsigned      frames;
      res.advanced = 1'b0;
      if (cmd == CMD_WRITE) begin
         seq_durations[slot] = dur;
      end else if (cfg_anim && !seq_halted) begin
         frames = (cfg_frame_count == 0) ? 1 :
                  (cfg_frame_count > SEQ_FRAMES) ? SEQ_FRAMES : 32'(cfg_frame_count);
         if (seq_frame >= frames) seq_frame = frame_type'(frames - 1);
         if (seq_elapsed != DURATION_MAX) seq_elapsed++;
         if (seq_elapsed >= seq_durations[seq_frame]) begin
            res.advanced = 1'b1;
            seq_elapsed = '0;
            if (cfg_pingpong) begin
               if (!seq_backward) begin
                  if (seq_frame + 1 >= frames) begin
                     seq_frame = (frames >= 2) ? frame_type'(frames - 2) : '0;
                     seq_backward = 1'b1;
                     if (!cfg_loop) seq_halted = 1'b1;
                  end else begin
                     seq_frame++;
                  end
               end else if (seq_frame > 0) begin
                  seq_frame--;
               end else begin
                  seq_frame = (frames >= 2) ? frame_type'(1) : '0;
                  seq_backward = 1'b0;
                  if (!cfg_loop) seq_halted = 1'b1;
               end
            end else if (seq_frame + 1 >= frames) begin
               if (cfg_loop) begin
                  seq_frame = '0;
               end else begin
                  seq_frame = frame_type'(frames - 1);
                  seq_halted = 1'b1;
               end
            end else begin
               seq_frame++;
            end
         end
      end
      res.frame_index = seq_frame;
      res.stopped = seq_halted;
      return res;
   endfunction

   function automatic int unsigned pick_gap(input bit enabled);
      if (!enabled) return 0;
      if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 2);
   endfunction

   function automatic duration_type pick_duration();
      int unsigned r;
      r = $urandom_range(0, 31);
      if (r == 0) return DURATION_MAX;
      if (r == 1) return duration_type'($urandom);
      if (r < 6) return duration_type'($urandom_range(5, 20));
      return duration_type'($urandom_range(0, 3));
   endfunction

   task automatic queue_cmd(input command_type cmd, input slot_type slot, input duration_type dur);
      sequencer_cmd_type item;
      item.command     = cmd;
      item.slot        = slot;
      item.duration_ms = dur;
      pending_cmds.insert(pending_cmds.size(), item);
      cmds_in_flight++;
   endtask

   task automatic queue_random_cmd();
      if ($urandom_range(0, 4) == 0)
         queue_cmd(CMD_WRITE, slot_type'($urandom), pick_duration());
      else
         queue_cmd(CMD_TICK, slot_type'($urandom), duration_type'($urandom));
   endtask

   task automatic wait_idle();
      while (cmds_in_flight != 0 || expected_reports.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_FRAME_COUNT: cfg_frame_count = data;
         CSR_LOOP_EN:     cfg_loop = data[0];
         CSR_PINGPONG_EN: cfg_pingpong = data[0];
         CSR_ANIM_EN:     cfg_anim = data[0];
         default: ;
      endcase
   endtask

   task automatic csr_write_flag(input csr_index_type idx, input logic flag);
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'($urandom);
      data[0] = flag;
      csr_write(idx, data);
   endtask

   task automatic random_settings(input logic loop_flag);
      int unsigned r;
      count_type   frames;
      r = $urandom_range(0, 9);
      if (r == 0) frames = '0;
      else if (r == 1) frames = count_type'(16);
      else if (r == 2) frames = count_type'($urandom_range(17, 31));
      else if (r == 3) frames = count_type'(1);
      else frames = count_type'($urandom_range(2, 8));
      csr_write(CSR_FRAME_COUNT, frames);
      csr_write_flag(CSR_LOOP_EN, loop_flag);
      csr_write_flag(CSR_PINGPONG_EN, $urandom_range(0, 1) != 0);
      csr_write_flag(CSR_ANIM_EN, $urandom_range(0, 7) != 0);
      send_idling = $urandom_range(0, 3) != 0;
      recv_idling = $urandom_range(0, 3) != 0;
   endtask

   // Driver: offers queued commands and predicts each one at its transfer.
   always @(posedge clock) begin
      sequencer_cmd_type cmd_next;
      logic              offer_free;
      if (reset) begin
         req_chan.valid       <= 1'b0;
         req_chan.command     <= CMD_TICK;
         req_chan.slot        <= '0;
         req_chan.duration_ms <= '0;
      end else begin
         offer_free = !req_chan.valid;
         if (req_chan.valid && req_chan.ready) begin
            expected_reports.insert(expected_reports.size(),
                                    step_sequencer(req_chan.command, req_chan.slot,
                                                   req_chan.duration_ms));
            cmds_in_flight--;
            offer_free = 1'b1;
            send_gap = pick_gap(send_idling);
         end
         if (offer_free) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               cmd_next = pending_cmds.pop_front();
               req_chan.valid       <= 1'b1;
               req_chan.command     <= cmd_next.command;
               req_chan.slot        <= cmd_next.slot;
               req_chan.duration_ms <= cmd_next.duration_ms;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(input string field, input int unsigned want,
                                  input int unsigned got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   // Monitor: checks each result transfer and applies back-pressure.
   always @(posedge clock) begin
      frame_report_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_reports.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual frame %0d adv %0b stop %0b",
                        $time, rsp_chan.frame_index, rsp_chan.advanced, rsp_chan.stopped);
            end else begin
               want = expected_reports.pop_front();
               if (rsp_chan.frame_index !== want.frame_index)
                  report_mismatch("frame_index", 32'(want.frame_index),
                                  32'(rsp_chan.frame_index));
               if (rsp_chan.advanced !== want.advanced)
                  report_mismatch("advanced", 32'(want.advanced), 32'(rsp_chan.advanced));
               if (rsp_chan.stopped !== want.stopped)
                  report_mismatch("stopped", 32'(want.stopped), 32'(rsp_chan.stopped));
            end
         end
         if (holds_done < hold_requests) begin
            holds_done++;
            recv_stall = LONG_HOLD;
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (recv_idling && $urandom_range(0, 3) == 0) recv_stall = pick_gap(1'b1);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Every duration is loaded before the first tick, with both extremes.
      for (int i = 0; i < SEQ_FRAMES; i++)
         queue_cmd(CMD_WRITE, slot_type'(i),
                   (i == 0) ? duration_type'(0) : (i == 1) ? DURATION_MAX :
                   duration_type'($urandom_range(1, 3)));
      queue_cmd(CMD_TICK, '0, '0);
      queue_cmd(CMD_TICK, '1, DURATION_MAX);
      wait_idle();

      // A single frame in ping-pong mode holds frame 0 at each turn.
      csr_write_flag(CSR_PINGPONG_EN, 1'b1);
      queue_cmd(CMD_TICK, '0, '0);
      queue_cmd(CMD_TICK, '0, '0);
      wait_idle();

      csr_write(CSR_FRAME_COUNT, 5'd0);
      queue_cmd(CMD_TICK, '0, '0);
      wait_idle();

      csr_write(CSR_FRAME_COUNT, 5'd31);
      csr_write_flag(CSR_PINGPONG_EN, 1'b0);
      queue_cmd(CMD_WRITE, 4'd1, 16'd1);
      repeat (3) queue_cmd(CMD_TICK, '0, '0);
      wait_idle();

      // Frozen ticks change nothing, while writes still land.
      csr_write_flag(CSR_ANIM_EN, 1'b0);
      queue_cmd(CMD_TICK, '0, '0);
      queue_cmd(CMD_WRITE, 4'd15, DURATION_MAX);
      wait_idle();
      csr_write_flag(CSR_ANIM_EN, 1'b1);

      for (int p = 0; p < PHASES; p++) begin
         random_settings(1'b1);
         if (p == 3) begin
            send_idling = 1'b0;
            csr_write_flag(CSR_ANIM_EN, 1'b1);
         end
         for (int i = 0; i < PHASE_ITEMS; i++) queue_random_cmd();
         if (p == 3) hold_requests++;
         wait_idle();
      end

      // Looping off last of all, since a pause at the end lasts until reset.
      random_settings(1'b0);
      csr_write(CSR_FRAME_COUNT, count_type'($urandom_range(1, 5)));
      csr_write_flag(CSR_ANIM_EN, 1'b1);
      for (int i = 0; i < PHASE_ITEMS; i++) queue_random_cmd();
      wait_idle();

      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
